// ----- rtl/gql_pkg.sv -----
// gql_pkg: shared types, register codes and saturation helpers for the glyph quad layout block
// used by every module under rtl; depends on nothing
`default_nettype none

package gql_pkg;

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_W    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LINE     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MONO_ADV = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_INV_W    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_INV_H    = 3'd7;

  // spacing mode of an item
  localparam logic FUNC_MONO = 1'b1;

  // depth of the queue between front and back
  localparam int QUEUE_DEPTH = 4;

  typedef logic signed [31:0] q_t;    // Q8.24 coordinate
  typedef logic signed [35:0] ext_t;  // headroom for unsaturated sums
  typedef logic [24:0]        tex_t;  // texture coordinate, 0 .. 1.0

  localparam ext_t Q_MAX_EXT = 36'sd2147483647;
  localparam ext_t Q_MIN_EXT = -36'sd2147483648;
  localparam q_t   Q_MAX     = 32'sh7fffffff;
  localparam q_t   Q_MIN     = 32'sh80000000;
  localparam tex_t TEX_ONE   = 25'd16777216;

  typedef struct packed {
    logic [24:0] scale;
    logic [31:0] origin_x;
    logic [31:0] origin_y;
    logic [30:0] box_width;
    logic [30:0] line_step;
    logic [13:0] mono_advance;
    logic [24:0] inv_w;
    logic [24:0] inv_h;
  } cfg_t;

  // one classified item waiting for the pen
  typedef struct packed {
    logic first;
    ext_t off;      // left edge relative to the pen
    ext_t thr;      // right limit minus glyph width
    logic max_top;  // right limit sits at the top of the range
    q_t   pxw;      // pen x after a line break
    ext_t radv;     // scaled horizontal advance
    ext_t rdy;      // scaled vertical advance
    ext_t sw;
    ext_t sbt;
    ext_t sh;
    tex_t tl;
    tex_t tr;
    tex_t tb;
  } fq_item_t;

  function automatic q_t sat32(input ext_t v);
    if (v > Q_MAX_EXT) begin
      return Q_MAX;
    end else if (v < Q_MIN_EXT) begin
      return Q_MIN;
    end
    return v[31:0];
  endfunction

  function automatic tex_t sat_tex(input logic [41:0] v);
    if (v > 42'(TEX_ONE)) begin
      return TEX_ONE;
    end
    return v[24:0];
  endfunction

endpackage

`default_nettype wire

// ----- rtl/gql_fifo.sv -----
// gql_fifo: small register queue that decouples the front from the back
// uses fq_item_t from gql_pkg
`default_nettype none

module gql_fifo
  import gql_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     push_valid,
  output logic          push_ready,
  input  wire fq_item_t push_data,
  output logic          pop_valid,
  input  wire logic     pop_ready,
  output fq_item_t      pop_data
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  fq_item_t        mem_r [DEPTH];
  logic [AW-1:0]   wr_ptr_r;
  logic [AW-1:0]   rd_ptr_r;
  logic [CW-1:0]   count_r;
  logic            do_push;
  logic            do_pop;

  assign push_ready = (count_r != CW'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + CW'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - CW'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/gql_front.sv -----
// gql_front: three-stage pipeline that scales glyph metrics and texture spans
// independent of the pen; depends on gql_pkg
`default_nettype none

module gql_front
  import gql_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire cfg_t        cfg,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_func,
  input  wire logic        in_first_of_string,
  input  wire logic [7:0]  in_glyph_w,
  input  wire logic [7:0]  in_glyph_h,
  input  wire logic signed [7:0]  in_bearing_left,
  input  wire logic signed [7:0]  in_bearing_top,
  input  wire logic [13:0] in_advance_x,
  input  wire logic signed [13:0] in_advance_y,
  input  wire logic [15:0] in_atlas_x,
  output logic             q_valid,
  input  wire logic        q_ready,
  output fq_item_t         q_item
);

  logic signed [25:0] scale_s;
  logic [13:0]        adv_sel;
  q_t                 ox;

  // stage 1: products
  logic               s1_valid_r;
  logic               s1_mono_r, s1_first_r;
  logic signed [33:0] s1_sbl_r, s1_sbl_nxt;
  logic [32:0]        s1_sw_r, s1_sw_nxt;
  logic signed [33:0] s1_sbt_r, s1_sbt_nxt;
  logic [32:0]        s1_sh_r, s1_sh_nxt;
  logic [38:0]        s1_pmono_r, s1_pmono_nxt;
  logic [38:0]        s1_padv_r, s1_padv_nxt;
  logic signed [39:0] s1_pay_r, s1_pay_nxt;
  logic [40:0]        s1_ptl_r, s1_ptl_nxt;
  logic [32:0]        s1_ptw_r, s1_ptw_nxt;
  logic [32:0]        s1_ph_r, s1_ph_nxt;

  // stage 2: rounding and texture clamps
  logic               s2_valid_r;
  logic               s2_mono_r, s2_first_r;
  ext_t               s2_sbl_r, s2_sw_r, s2_sbt_r, s2_sh_r;
  ext_t               s2_rmono_r, s2_rmono_nxt;
  ext_t               s2_radv_r, s2_radv_nxt;
  ext_t               s2_rdy_r, s2_rdy_nxt;
  ext_t               s2_diff_r, s2_diff_nxt;
  tex_t               s2_tl_r, s2_tl_nxt;
  tex_t               s2_tb_r, s2_tb_nxt;
  logic [32:0]        s2_ptw_r;
  logic [39:0]        rnd_mono, rnd_adv;
  logic signed [39:0] rnd_ay, rnd_ay_sh;

  // stage 3: item for the queue
  logic               s3_valid_r;
  fq_item_t           s3_item_r, s3_item_nxt;

  // right limit of the box, follows the registers
  ext_t               maxx_r;
  logic               maxtop_r;
  q_t                 maxx_sat;

  logic               rdy1, rdy2, rdy3;

  assign rdy3     = !s3_valid_r || q_ready;
  assign rdy2     = !s2_valid_r || rdy3;
  assign rdy1     = !s1_valid_r || rdy2;
  assign in_stall = !rdy1;
  assign q_valid  = s3_valid_r;
  assign q_item   = s3_item_r;

  assign scale_s  = $signed({1'b0, cfg.scale});
  assign adv_sel  = (in_func == FUNC_MONO) ? cfg.mono_advance : in_advance_x;
  assign ox       = $signed(cfg.origin_x);
  assign maxx_sat = sat32(ext_t'(ox) + ext_t'(cfg.box_width));

  always_comb begin
    s1_sbl_nxt   = 34'(scale_s) * 34'(in_bearing_left);
    s1_sw_nxt    = 33'(cfg.scale) * 33'(in_glyph_w);
    s1_sbt_nxt   = 34'(scale_s) * 34'(in_bearing_top);
    s1_sh_nxt    = 33'(cfg.scale) * 33'(in_glyph_h);
    s1_pmono_nxt = 39'(cfg.scale) * 39'(cfg.mono_advance);
    s1_padv_nxt  = 39'(cfg.scale) * 39'(adv_sel);
    s1_pay_nxt   = 40'(scale_s) * 40'(in_advance_y);
    s1_ptl_nxt   = 41'(in_atlas_x) * 41'(cfg.inv_w);
    s1_ptw_nxt   = 33'(in_glyph_w) * 33'(cfg.inv_w);
    s1_ph_nxt    = 33'(in_glyph_h) * 33'(cfg.inv_h);
  end

  // divide by 64, round to nearest with ties upward
  always_comb begin
    rnd_mono     = 40'(s1_pmono_r) + 40'd32;
    rnd_adv      = 40'(s1_padv_r) + 40'd32;
    rnd_ay       = s1_pay_r + 40'sd32;
    rnd_ay_sh    = rnd_ay >>> 6;
    s2_rmono_nxt = ext_t'(rnd_mono[39:6]);
    s2_radv_nxt  = ext_t'(rnd_adv[39:6]);
    s2_rdy_nxt   = ext_t'(rnd_ay_sh);
    s2_diff_nxt  = ext_t'(s1_sbl_r) - ext_t'(s1_sw_r);
    s2_tl_nxt    = sat_tex(42'(s1_ptl_r));
    s2_tb_nxt    = sat_tex(42'(s1_ph_r));
  end

  always_comb begin
    s3_item_nxt.first   = s2_first_r;
    s3_item_nxt.off     = s2_mono_r ? (s2_diff_r + s2_rmono_r) : s2_sbl_r;
    s3_item_nxt.thr     = maxx_r - s2_sw_r;
    s3_item_nxt.max_top = maxtop_r;
    s3_item_nxt.pxw     = sat32(ext_t'(ox) + s2_radv_r);
    s3_item_nxt.radv    = s2_radv_r;
    s3_item_nxt.rdy     = s2_rdy_r;
    s3_item_nxt.sw      = s2_sw_r;
    s3_item_nxt.sbt     = s2_sbt_r;
    s3_item_nxt.sh      = s2_sh_r;
    s3_item_nxt.tl      = s2_tl_r;
    s3_item_nxt.tr      = sat_tex(42'(s2_tl_r) + 42'(s2_ptw_r));
    s3_item_nxt.tb      = s2_tb_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
    end else begin
      if (rdy1) begin
        s1_valid_r <= in_valid;
      end
      if (rdy2) begin
        s2_valid_r <= s1_valid_r;
      end
      if (rdy3) begin
        s3_valid_r <= s2_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    maxx_r   <= ext_t'(maxx_sat);
    maxtop_r <= (maxx_sat == Q_MAX);
    if (rdy1 && in_valid) begin
      s1_mono_r  <= (in_func == FUNC_MONO);
      s1_first_r <= in_first_of_string;
      s1_sbl_r   <= s1_sbl_nxt;
      s1_sw_r    <= s1_sw_nxt;
      s1_sbt_r   <= s1_sbt_nxt;
      s1_sh_r    <= s1_sh_nxt;
      s1_pmono_r <= s1_pmono_nxt;
      s1_padv_r  <= s1_padv_nxt;
      s1_pay_r   <= s1_pay_nxt;
      s1_ptl_r   <= s1_ptl_nxt;
      s1_ptw_r   <= s1_ptw_nxt;
      s1_ph_r    <= s1_ph_nxt;
    end
    if (rdy2 && s1_valid_r) begin
      s2_mono_r  <= s1_mono_r;
      s2_first_r <= s1_first_r;
      s2_sbl_r   <= ext_t'(s1_sbl_r);
      s2_sw_r    <= ext_t'(s1_sw_r);
      s2_sbt_r   <= ext_t'(s1_sbt_r);
      s2_sh_r    <= ext_t'(s1_sh_r);
      s2_rmono_r <= s2_rmono_nxt;
      s2_radv_r  <= s2_radv_nxt;
      s2_rdy_r   <= s2_rdy_nxt;
      s2_diff_r  <= s2_diff_nxt;
      s2_tl_r    <= s2_tl_nxt;
      s2_tb_r    <= s2_tb_nxt;
      s2_ptw_r   <= s1_ptw_r;
    end
    if (rdy3 && s2_valid_r) begin
      s3_item_r <= s3_item_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/gql_back.sv -----
// gql_back: pen update, line-break decision and final edge sums
// takes classified items from the queue; depends on gql_pkg
`default_nettype none

module gql_back
  import gql_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire cfg_t     cfg,
  input  wire logic     q_valid,
  output logic          q_ready,
  input  wire fq_item_t q_item,
  output logic          out_valid,
  input  wire logic     out_stall,
  output q_t            out_x_left,
  output q_t            out_x_right,
  output q_t            out_y_bottom,
  output q_t            out_y_top,
  output tex_t          out_tex_left,
  output tex_t          out_tex_right,
  output tex_t          out_tex_bottom,
  output logic          out_wrapped
);

  q_t   ox, oy;
  q_t   pen_x_r, pen_x_nxt;
  q_t   pen_y_r, pen_y_nxt;
  q_t   px0, py0, pyw, py1, x1a, x1b;
  logic wrap;
  logic pop;

  // stage b1
  logic b1_valid_r, b1_wrap_r;
  q_t   b1_x1_r, b1_py1_r;
  ext_t b1_sw_r, b1_sbt_r, b1_sh_r;
  tex_t b1_tl_r, b1_tr_r, b1_tb_r;

  // stage b2
  logic b2_valid_r, b2_wrap_r;
  q_t   b2_x1_r, b2_x2_r, b2_y2_r;
  ext_t b2_sh_r;
  tex_t b2_tl_r, b2_tr_r, b2_tb_r;

  logic rdy_b1, rdy_b2, rdy_b3;

  assign rdy_b3  = !out_valid || !out_stall;
  assign rdy_b2  = !b2_valid_r || rdy_b3;
  assign rdy_b1  = !b1_valid_r || rdy_b2;
  assign q_ready = rdy_b1;
  assign pop     = q_valid && rdy_b1;

  assign ox = $signed(cfg.origin_x);
  assign oy = $signed(cfg.origin_y);

  // the pen recurrence: one item per cycle while an item is queued and the output is not stalled
  always_comb begin
    px0  = q_item.first ? ox : pen_x_r;
    py0  = q_item.first ? oy : pen_y_r;
    x1a  = sat32(ext_t'(px0) + q_item.off);
    x1b  = sat32(ext_t'(ox) + q_item.off);
    // right edge past the limit, tested as left edge past limit minus width
    wrap = !q_item.max_top && (ext_t'(x1a) > q_item.thr) && (px0 != ox);
    pyw  = sat32(ext_t'(py0) - ext_t'(cfg.line_step));
    py1  = wrap ? pyw : py0;
    pen_x_nxt = wrap ? q_item.pxw : sat32(ext_t'(px0) + q_item.radv);
    pen_y_nxt = sat32(ext_t'(py1) + q_item.rdy);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pen_x_r    <= '0;
      pen_y_r    <= '0;
      b1_valid_r <= 1'b0;
      b2_valid_r <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (pop) begin
        pen_x_r <= pen_x_nxt;
        pen_y_r <= pen_y_nxt;
      end
      if (rdy_b1) begin
        b1_valid_r <= q_valid;
      end
      if (rdy_b2) begin
        b2_valid_r <= b1_valid_r;
      end
      if (rdy_b3) begin
        out_valid <= b2_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      b1_wrap_r <= wrap;
      b1_x1_r   <= wrap ? x1b : x1a;
      b1_py1_r  <= py1;
      b1_sw_r   <= q_item.sw;
      b1_sbt_r  <= q_item.sbt;
      b1_sh_r   <= q_item.sh;
      b1_tl_r   <= q_item.tl;
      b1_tr_r   <= q_item.tr;
      b1_tb_r   <= q_item.tb;
    end
    if (rdy_b2 && b1_valid_r) begin
      b2_wrap_r <= b1_wrap_r;
      b2_x1_r   <= b1_x1_r;
      b2_x2_r   <= sat32(ext_t'(b1_x1_r) + b1_sw_r);
      b2_y2_r   <= sat32(ext_t'(b1_py1_r) + b1_sbt_r);
      b2_sh_r   <= b1_sh_r;
      b2_tl_r   <= b1_tl_r;
      b2_tr_r   <= b1_tr_r;
      b2_tb_r   <= b1_tb_r;
    end
    if (rdy_b3 && b2_valid_r) begin
      out_x_left     <= b2_x1_r;
      out_x_right    <= b2_x2_r;
      out_y_top      <= b2_y2_r;
      out_y_bottom   <= sat32(ext_t'(b2_y2_r) - b2_sh_r);
      out_tex_left   <= b2_tl_r;
      out_tex_right  <= b2_tr_r;
      out_tex_bottom <= b2_tb_r;
      out_wrapped    <= b2_wrap_r;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/glyph_quad_layout.sv -----
// glyph_quad_layout: top level with configuration registers, front, queue and back
// depends on gql_pkg, gql_front, gql_fifo and gql_back
`default_nettype none

// Places one glyph quad per item at a sustained rate of one item per
// clock while out_stall is low. An item is accepted when in_valid is
// high and in_stall low. The front pipeline (three stages) does all
// multiplies and texture spans; the back keeps the pen and updates it
// once per item, which is the loop that sets the rate. A short queue
// between them absorbs back pressure from out_stall.
// Configuration writes are always taken (cfg_ready is held high) and apply
// to items accepted after the write; write registers only while idle.

module glyph_quad_layout
  import gql_pkg::*;
#(
  parameter int QDEPTH = QUEUE_DEPTH
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [31:0]          cfg_data,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic                 in_func,
  input  wire logic                 in_first_of_string,
  input  wire logic [7:0]           in_glyph_w,
  input  wire logic [7:0]           in_glyph_h,
  input  wire logic signed [7:0]    in_bearing_left,
  input  wire logic signed [7:0]    in_bearing_top,
  input  wire logic [13:0]          in_advance_x,
  input  wire logic signed [13:0]   in_advance_y,
  input  wire logic [15:0]          in_atlas_x,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic signed [31:0]        out_x_left,
  output logic signed [31:0]        out_x_right,
  output logic signed [31:0]        out_y_bottom,
  output logic signed [31:0]        out_y_top,
  output logic [24:0]               out_tex_left,
  output logic [24:0]               out_tex_right,
  output logic [24:0]               out_tex_bottom,
  output logic                      out_wrapped
);

  cfg_t     cfg_r;
  logic     q_push_valid, q_push_ready;
  fq_item_t q_push_data;
  logic     q_pop_valid, q_pop_ready;
  fq_item_t q_pop_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_SCALE:    cfg_r.scale        <= cfg_data[24:0];
        REG_ORIGIN_X: cfg_r.origin_x     <= cfg_data;
        REG_ORIGIN_Y: cfg_r.origin_y     <= cfg_data;
        REG_BOX_W:    cfg_r.box_width    <= cfg_data[30:0];
        REG_LINE:     cfg_r.line_step    <= cfg_data[30:0];
        REG_MONO_ADV: cfg_r.mono_advance <= cfg_data[13:0];
        REG_INV_W:    cfg_r.inv_w        <= cfg_data[24:0];
        REG_INV_H:    cfg_r.inv_h        <= cfg_data[24:0];
      endcase
    end
  end

  gql_front u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg                (cfg_r),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_func            (in_func),
    .in_first_of_string (in_first_of_string),
    .in_glyph_w         (in_glyph_w),
    .in_glyph_h         (in_glyph_h),
    .in_bearing_left    (in_bearing_left),
    .in_bearing_top     (in_bearing_top),
    .in_advance_x       (in_advance_x),
    .in_advance_y       (in_advance_y),
    .in_atlas_x         (in_atlas_x),
    .q_valid            (q_push_valid),
    .q_ready            (q_push_ready),
    .q_item             (q_push_data)
  );

  gql_fifo #(
    .DEPTH (QDEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (q_push_valid),
    .push_ready (q_push_ready),
    .push_data  (q_push_data),
    .pop_valid  (q_pop_valid),
    .pop_ready  (q_pop_ready),
    .pop_data   (q_pop_data)
  );

  gql_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg_r),
    .q_valid        (q_pop_valid),
    .q_ready        (q_pop_ready),
    .q_item         (q_pop_data),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_x_left     (out_x_left),
    .out_x_right    (out_x_right),
    .out_y_bottom   (out_y_bottom),
    .out_y_top      (out_y_top),
    .out_tex_left   (out_tex_left),
    .out_tex_right  (out_tex_right),
    .out_tex_bottom (out_tex_bottom),
    .out_wrapped    (out_wrapped)
  );

endmodule

`default_nettype wire

// ----- rtl/gql_checker.sv -----
// gql_checker: port-level assertions for glyph_quad_layout, bound to the top level
// depends on gql_pkg for the texture limit
`default_nettype none

module gql_checker
  import gql_pkg::*;
(
  input wire logic                 clk,
  input wire logic                 rst_n,
  input wire logic                 out_valid,
  input wire logic                 out_stall,
  input wire logic signed [31:0]   out_x_left,
  input wire logic signed [31:0]   out_x_right,
  input wire logic signed [31:0]   out_y_bottom,
  input wire logic signed [31:0]   out_y_top,
  input wire logic [24:0]          out_tex_left,
  input wire logic [24:0]          out_tex_right,
  input wire logic [24:0]          out_tex_bottom,
  input wire logic                 out_wrapped
);

  // no item left over from before reset
  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("out_valid set right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_x_left) && $stable(out_x_right)
      && $stable(out_y_bottom) && $stable(out_y_top) && $stable(out_tex_left)
      && $stable(out_tex_right) && $stable(out_tex_bottom) && $stable(out_wrapped))
    else $error("stalled result changed");

  // widths and heights are never negative, so quads are never inverted
  a_quad_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_x_right >= out_x_left) && (out_y_top >= out_y_bottom))
    else $error("quad edges out of order");

  a_tex_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_tex_right >= out_tex_left) && (out_tex_right <= TEX_ONE)
      && (out_tex_bottom <= TEX_ONE))
    else $error("texture span out of range");

endmodule

bind glyph_quad_layout gql_checker u_gql_checker (.*);

`default_nettype wire
